// ===== hdl/adsr_pkg.sv =====
// Shared constants, stage codes and divider interface types for the ADSR envelope core.
package adsr_pkg;

   // Level format: Q1.LEVEL_FRAC_BITS, one integer bit above the fraction
   localparam int LEVEL_FRAC_BITS  = 16;
   localparam int LEVEL_W          = LEVEL_FRAC_BITS + 1;
   localparam int LEN_W            = 20;
   localparam int SUSTAIN_W        = 17;
   localparam int EXP_W            = 5;
   localparam int DELAY_W          = 24;
   localparam int FUNC_W           = 2;
   localparam int STAGE_W          = 3;
   localparam int POS_W            = 32;
   localparam int REM_W            = 31;
   localparam int MAX_EXPONENT_DEF = 20;

   // Stream payload widths
   localparam int REQ_DATA_W = ((DELAY_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((LEVEL_W + POS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - LEVEL_W - POS_W;

   // Register file port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_LEN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_LEN      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUSTAIN_LEVEL  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_LEN    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURVE_EXPONENT = 3'd4;

   localparam logic [LEN_W-1:0]     ATTACK_LEN_RST     = 20'd384;
   localparam logic [LEN_W-1:0]     DECAY_LEN_RST      = 20'd9600;
   localparam logic [SUSTAIN_W-1:0] SUSTAIN_LEVEL_RST  = 17'd26214;
   localparam logic [LEN_W-1:0]     RELEASE_LEN_RST    = 20'd14400;
   localparam logic [EXP_W-1:0]     CURVE_EXPONENT_RST = 5'd2;

   localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC_BITS;

   // Sustain stage length (largest signed 32-bit value)
   localparam logic [REM_W-1:0] SUSTAIN_SAMPLES = REM_W'(32'h7FFF_FFFF);

   typedef enum logic [STAGE_W-1:0] {
      STAGE_DELAY   = 3'd0,
      STAGE_ATTACK  = 3'd1,
      STAGE_DECAY   = 3'd2,
      STAGE_SUSTAIN = 3'd3,
      STAGE_RELEASE = 3'd4,
      STAGE_DONE    = 3'd5
   } stage_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_START   = 2'd1,
      FUNC_RELEASE = 2'd2
   } func_type;

   // Ratio divider request and response
   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] num;
      logic [LEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [LEVEL_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== hdl/adsr_div.sv =====
// Restoring divider: round((num << F) / den) for num < den, one quotient bit per cycle.
module adsr_div (
   input  logic                clock,
   input  logic                reset,
   input  adsr_pkg::div_req_type div_req,
   output adsr_pkg::div_rsp_type div_rsp
);
   import adsr_pkg::*;

   localparam int NUM_W = LEN_W + LEVEL_FRAC_BITS + 1;
   localparam int CNT_W = $clog2(LEVEL_W + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [LEN_W-1:0]    part_ff;
   logic [LEN_W-1:0]    den_ff;
   logic [LEVEL_W-1:0]  shift_ff;

   logic [NUM_W-1:0]    num_full;
   logic [LEN_W:0]      trial;
   logic                fits;

   // Rounded numerator: (num << F) + den / 2
   assign num_full = {1'b0, div_req.num, LEVEL_FRAC_BITS'(0)} + NUM_W'(div_req.den >> 1);

   // Bring down the next dividend bit and try the subtract
   assign trial = {part_ff, shift_ff[LEVEL_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   // Sequence control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(LEVEL_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Partial remainder and dividend/quotient shift register
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         part_ff  <= num_full[NUM_W-1:LEVEL_W];
         shift_ff <= num_full[LEVEL_W-1:0];
         den_ff   <= div_req.den;
      end else if (busy_ff) begin
         part_ff  <= fits ? LEN_W'(trial - {1'b0, den_ff}) : trial[LEN_W-1:0];
         shift_ff <= {shift_ff[LEVEL_W-2:0], fits};
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = shift_ff;

endmodule

// ===== hdl/adsr_mul.sv =====
// Registered fixed-point multiplier: (a * b + half) >> F.
module adsr_mul (
   input  logic                          clock,
   input  logic [adsr_pkg::LEVEL_W-1:0]  mul_a,
   input  logic [adsr_pkg::LEVEL_W-1:0]  mul_b,
   output logic [adsr_pkg::LEVEL_W-1:0]  product
);
   import adsr_pkg::*;

   localparam int PROD_W = 2 * LEVEL_W + 1;
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (LEVEL_FRAC_BITS - 1);

   logic [PROD_W-1:0]  wide;
   logic [LEVEL_W-1:0] product_ff;

   // Round half up, then drop the fraction
   assign wide = PROD_W'(mul_a) * PROD_W'(mul_b) + HALF;

   always_ff @(posedge clock) begin
      product_ff <= wide[LEVEL_FRAC_BITS +: LEVEL_W];
   end

   assign product = product_ff;

endmodule

// ===== hdl/adsr_envelope_generator_core.sv =====
// ADSR envelope core: stage sequencer around a shared divider and multiplier.
// Sequence: start and release items are handled in the idle state. A tick's ramp ratio goes
//   through the divider when needed, then is raised to the curve exponent and scaled; delay
//   and sustain skip both. Each empty stage adds a skip step; a release begun on the tick in
//   attack, decay or sustain adds a second level pass. Throughput: one item in work at a time.
// Reset: synchronous; control and CSR registers take their defaults, stage returns to delay.
module adsr_envelope_generator_core #(
   parameter int MAX_EXPONENT = adsr_pkg::MAX_EXPONENT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [adsr_pkg::REQ_DATA_W-1:0]    req_tdata,   // [23:0] delay
   input  logic [adsr_pkg::FUNC_W-1:0]        req_tuser,   // [1:0] func
   // Result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [adsr_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [16:0] level, [48:17] position
   output logic [adsr_pkg::STAGE_W-1:0]       rsp_tuser,   // [2:0] stage
   // Register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [adsr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [adsr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import adsr_pkg::*;

   localparam int KCNT_W  = $clog2(MAX_EXPONENT + 1);
   localparam int ACC_W   = LEN_W + 2;
   localparam int WIDE_W  = POS_W + 3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SKIP,
      S_RELCHK,
      S_LVL,
      S_DIV,
      S_POW,
      S_SCALE,
      S_FIN,
      S_UPDATE,
      S_POS1,
      S_POS2,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_PRE,
      PH_REL,
      PH_POST
   } phase_type;

   // Registers
   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   stage_type            stage_ff, stage_in;
   logic [REM_W-1:0]     remaining_ff, remaining_in;
   logic                 pending_ff, pending_in;
   logic [DELAY_W-1:0]   countdown_ff, countdown_in;
   logic [LEVEL_W-1:0]   rel_start_ff, rel_start_in;
   logic [POS_W-1:0]     sustain_time_ff, sustain_time_in;
   logic                 rel_level_ff, rel_level_in;
   logic [LEN_W-1:0]     attack_len_ff, attack_len_in;
   logic [LEN_W-1:0]     decay_len_ff, decay_len_in;
   logic [SUSTAIN_W-1:0] sustain_level_ff, sustain_level_in;
   logic [LEN_W-1:0]     release_len_ff, release_len_in;
   logic [EXP_W-1:0]     curve_exp_ff, curve_exp_in;
   logic [KCNT_W-1:0]    pow_count_ff, pow_count_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [LEVEL_W-1:0]   ratio_ff, ratio_in;
   logic [ACC_W-1:0]     pos_acc_ff, pos_acc_in;
   logic [POS_W-1:0]     position_ff, position_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;
   stage_type            rsp_stage_ff, rsp_stage_in;
   logic [POS_W-1:0]     rsp_position_ff, rsp_position_in;

   // Datapath helpers
   logic [LEVEL_W-1:0]   sustain_val;
   logic [KCNT_W-1:0]    exp_k;
   logic                 stage_live;
   logic                 skip_needed;
   stage_type            adv_stage;
   logic [REM_W-1:0]     adv_rem;
   logic [LEN_W-1:0]     ramp_den;
   logic [REM_W-1:0]     ramp_num;
   logic                 ramp_trivial;
   logic [LEVEL_W-1:0]   scale_b;
   logic [LEVEL_W-1:0]   mul_a;
   logic [LEVEL_W-1:0]   mul_b;
   logic [LEVEL_W-1:0]   mul_q;
   logic                 lvl_commit;
   logic [LEVEL_W-1:0]   lvl_val;
   logic [WIDE_W-1:0]    pos_wide;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   // Shared units
   adsr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   adsr_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (mul_q)
   );

   // Clamp sustain to full scale and exponent to 1..MAX_EXPONENT
   assign sustain_val = (sustain_level_ff > LEVEL_ONE) ? LEVEL_ONE : sustain_level_ff;

   always_comb begin
      if (curve_exp_ff == '0) begin
         exp_k = KCNT_W'(1);
      end else if (int'(curve_exp_ff) > MAX_EXPONENT) begin
         exp_k = KCNT_W'(MAX_EXPONENT);
      end else begin
         exp_k = KCNT_W'(curve_exp_ff);
      end
   end

   assign stage_live  = (stage_ff != STAGE_DONE);
   assign skip_needed = stage_live && (remaining_ff == '0);

   // Next stage and its length when the current one is empty
   always_comb begin
      unique case (stage_ff)
         STAGE_DELAY: begin
            adv_stage = STAGE_ATTACK;
            adv_rem   = REM_W'(attack_len_ff);
         end
         STAGE_ATTACK: begin
            adv_stage = STAGE_DECAY;
            adv_rem   = REM_W'(decay_len_ff);
         end
         STAGE_DECAY: begin
            adv_stage = STAGE_SUSTAIN;
            adv_rem   = SUSTAIN_SAMPLES;
         end
         STAGE_SUSTAIN: begin
            adv_stage = STAGE_RELEASE;
            adv_rem   = REM_W'(release_len_ff);
         end
         default: begin
            adv_stage = STAGE_DONE;
            adv_rem   = '0;
         end
      endcase
   end

   // Ramp ratio operands and scale factor for the current stage
   always_comb begin
      unique case (stage_ff)
         STAGE_ATTACK: begin
            ramp_den = attack_len_ff;
            ramp_num = (remaining_ff >= REM_W'(attack_len_ff)) ? '0
                       : REM_W'(attack_len_ff) - remaining_ff;
            scale_b  = LEVEL_ONE;
         end
         STAGE_DECAY: begin
            ramp_den = decay_len_ff;
            ramp_num = remaining_ff;
            scale_b  = LEVEL_ONE - sustain_val;
         end
         default: begin
            ramp_den = release_len_ff;
            ramp_num = remaining_ff;
            scale_b  = rel_start_ff;
         end
      endcase
   end

   assign ramp_trivial = (ramp_den == '0) || (ramp_num >= REM_W'(ramp_den));

   // Multiplier operands: power chain starts from 1.0, then the stage scale
   assign mul_a = ((state_ff == S_POW) && (pow_count_ff == '0)) ? LEVEL_ONE : mul_q;
   assign mul_b = (state_ff == S_SCALE) ? scale_b : ratio_ff;

   // Position before clamping
   assign pos_wide = WIDE_W'(pos_acc_ff)
      + (((stage_ff == STAGE_SUSTAIN) || (stage_ff == STAGE_RELEASE) ||
          (stage_ff == STAGE_DONE)) ? WIDE_W'(sustain_time_ff) : WIDE_W'(0))
      - ((stage_ff != STAGE_SUSTAIN) ? WIDE_W'(remaining_ff) : WIDE_W'(0));

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      stage_in         = stage_ff;
      remaining_in     = remaining_ff;
      pending_in       = pending_ff;
      countdown_in     = countdown_ff;
      rel_start_in     = rel_start_ff;
      sustain_time_in  = sustain_time_ff;
      rel_level_in     = rel_level_ff;
      attack_len_in    = attack_len_ff;
      decay_len_in     = decay_len_ff;
      sustain_level_in = sustain_level_ff;
      release_len_in   = release_len_ff;
      curve_exp_in     = curve_exp_ff;
      pow_count_in     = pow_count_ff;
      level_in         = level_ff;
      ratio_in         = ratio_ff;
      pos_acc_in       = pos_acc_ff;
      position_in      = position_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_level_in     = rsp_level_ff;
      rsp_stage_in     = rsp_stage_ff;
      rsp_position_in  = rsp_position_ff;
      div_req.start    = 1'b0;
      div_req.num      = ramp_num[LEN_W-1:0];
      div_req.den      = ramp_den;
      lvl_commit       = 1'b0;
      lvl_val          = '0;

      // Register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ATTACK_LEN:     attack_len_in    = csr_data[LEN_W-1:0];
            CSR_DECAY_LEN:      decay_len_in     = csr_data[LEN_W-1:0];
            CSR_SUSTAIN_LEVEL:  sustain_level_in = csr_data[SUSTAIN_W-1:0];
            CSR_RELEASE_LEN:    release_len_in   = csr_data[LEN_W-1:0];
            CSR_CURVE_EXPONENT: curve_exp_in     = csr_data[EXP_W-1:0];
            default: ;
         endcase
      end

      // Drop the result once transferred
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               unique case (req_tuser)
                  FUNC_TICK: begin
                     phase_in = PH_PRE;
                     state_in = S_SKIP;
                  end
                  FUNC_START: begin
                     stage_in        = STAGE_DELAY;
                     remaining_in    = REM_W'(req_tdata[DELAY_W-1:0]);
                     pending_in      = 1'b0;
                     countdown_in    = '0;
                     rel_start_in    = '0;
                     sustain_time_in = '0;
                  end
                  FUNC_RELEASE: begin
                     pending_in   = 1'b1;
                     countdown_in = req_tdata[DELAY_W-1:0];
                  end
                  default: ;
               endcase
            end
         end

         // Step over empty stages one at a time
         S_SKIP: begin
            if (skip_needed) begin
               stage_in     = adv_stage;
               remaining_in = adv_rem;
            end else begin
               unique case (phase_ff)
                  PH_PRE: state_in = S_RELCHK;
                  PH_REL: begin
                     if (stage_live) begin
                        rel_level_in = 1'b0;
                        state_in     = S_LVL;
                     end else begin
                        level_in = '0;
                        state_in = S_POS1;
                     end
                  end
                  default: state_in = S_POS1;
               endcase
            end
         end

         // Begin a scheduled release whose countdown has run out
         S_RELCHK: begin
            if (stage_live && pending_ff && (countdown_ff == '0)) begin
               pending_in = 1'b0;
               if (stage_ff == STAGE_RELEASE) begin
                  rel_level_in = 1'b0;
                  state_in     = S_LVL;
               end else if (stage_ff == STAGE_DELAY) begin
                  rel_start_in = sustain_val;
                  stage_in     = STAGE_RELEASE;
                  remaining_in = REM_W'(release_len_ff);
                  phase_in     = PH_REL;
                  state_in     = S_SKIP;
               end else begin
                  rel_level_in = 1'b1;
                  state_in     = S_LVL;
               end
            end else if (stage_live) begin
               rel_level_in = 1'b0;
               state_in     = S_LVL;
            end else begin
               level_in = '0;
               state_in = S_POS1;
            end
         end

         // Flat stages finish at once, ramps go through ratio and power
         S_LVL: begin
            pow_count_in = '0;
            unique case (stage_ff)
               STAGE_DELAY: begin
                  lvl_commit = 1'b1;
                  lvl_val    = '0;
               end
               STAGE_SUSTAIN: begin
                  lvl_commit = 1'b1;
                  lvl_val    = sustain_val;
               end
               default: begin
                  if (ramp_trivial) begin
                     ratio_in = LEVEL_ONE;
                     state_in = S_POW;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
            endcase
         end

         S_DIV: begin
            if (div_rsp.done) begin
               ratio_in = div_rsp.quot;
               state_in = S_POW;
            end
         end

         // One multiply per cycle through the power chain
         S_POW: begin
            pow_count_in = pow_count_ff + 1'b1;
            if (pow_count_ff == exp_k - 1'b1) begin
               state_in = S_SCALE;
            end
         end

         S_SCALE: state_in = S_FIN;

         S_FIN: begin
            lvl_commit = 1'b1;
            lvl_val    = ((stage_ff == STAGE_DECAY) ? sustain_val : '0) + mul_q;
         end

         // Advance the counters by one sample
         S_UPDATE: begin
            remaining_in = remaining_ff - 1'b1;
            if ((stage_ff == STAGE_SUSTAIN) && (sustain_time_ff != '1)) begin
               sustain_time_in = sustain_time_ff + 1'b1;
            end
            if (pending_ff && (countdown_ff != '0)) begin
               countdown_in = countdown_ff - 1'b1;
            end
            phase_in = PH_POST;
            state_in = S_SKIP;
         end

         // Sum of ramp stage lengths through the end of the current stage
         S_POS1: begin
            unique case (stage_ff)
               STAGE_ATTACK:  pos_acc_in = ACC_W'(attack_len_ff);
               STAGE_DECAY,
               STAGE_SUSTAIN: pos_acc_in = ACC_W'(attack_len_ff) + ACC_W'(decay_len_ff);
               STAGE_RELEASE,
               STAGE_DONE:    pos_acc_in = ACC_W'(attack_len_ff) + ACC_W'(decay_len_ff)
                                           + ACC_W'(release_len_ff);
               default:       pos_acc_in = '0;
            endcase
            state_in = S_POS2;
         end

         // Add sustain time from sustain on, subtract what is left outside sustain, saturate
         S_POS2: begin
            if (pos_wide[WIDE_W-1]) begin
               position_in = '0;
            end else if (|pos_wide[WIDE_W-2:POS_W]) begin
               position_in = '1;
            end else begin
               position_in = pos_wide[POS_W-1:0];
            end
            state_in = S_OUT;
         end

         // Load the output register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in    = 1'b1;
               rsp_level_in    = level_ff;
               rsp_stage_in    = stage_ff;
               rsp_position_in = position_ff;
               state_in        = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Level ready: either it starts a release or it is this tick's output
      if (lvl_commit) begin
         if (rel_level_ff) begin
            rel_start_in = lvl_val;
            stage_in     = STAGE_RELEASE;
            remaining_in = REM_W'(release_len_ff);
            rel_level_in = 1'b0;
            phase_in     = PH_REL;
            state_in     = S_SKIP;
         end else begin
            level_in = lvl_val;
            state_in = S_UPDATE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         phase_ff         <= PH_PRE;
         stage_ff         <= STAGE_DELAY;
         remaining_ff     <= '0;
         pending_ff       <= 1'b0;
         countdown_ff     <= '0;
         rel_start_ff     <= '0;
         sustain_time_ff  <= '0;
         rel_level_ff     <= 1'b0;
         attack_len_ff    <= ATTACK_LEN_RST;
         decay_len_ff     <= DECAY_LEN_RST;
         sustain_level_ff <= SUSTAIN_LEVEL_RST;
         release_len_ff   <= RELEASE_LEN_RST;
         curve_exp_ff     <= CURVE_EXPONENT_RST;
         pow_count_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         phase_ff         <= phase_in;
         stage_ff         <= stage_in;
         remaining_ff     <= remaining_in;
         pending_ff       <= pending_in;
         countdown_ff     <= countdown_in;
         rel_start_ff     <= rel_start_in;
         sustain_time_ff  <= sustain_time_in;
         rel_level_ff     <= rel_level_in;
         attack_len_ff    <= attack_len_in;
         decay_len_ff     <= decay_len_in;
         sustain_level_ff <= sustain_level_in;
         release_len_ff   <= release_len_in;
         curve_exp_ff     <= curve_exp_in;
         pow_count_ff     <= pow_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      level_ff        <= level_in;
      ratio_ff        <= ratio_in;
      pos_acc_ff      <= pos_acc_in;
      position_ff     <= position_in;
      rsp_level_ff    <= rsp_level_in;
      rsp_stage_ff    <= rsp_stage_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_position_ff, rsp_level_ff};
   assign rsp_tuser  = rsp_stage_ff;

endmodule
